// ===== rtl/cbmt_pkg.sv =====
`default_nettype none
package cbmt_pkg;

	localparam int unsigned NUM_COUNTERS_DEF = 64;
	localparam int unsigned COUNT_WIDTH_DEF  = 16;

	localparam int unsigned ACTION_W = 2;
	localparam int unsigned INDEX_W  = 6;
	localparam int unsigned HOLD_W   = 7;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INC   = 2'd0,
		ACT_DEC   = 2'd1,
		ACT_CLR   = 2'd2,
		ACT_QUERY = 2'd3
	} action_t;

	// control part of an item as it walks down the row
	typedef struct packed {
		logic                 valid;
		action_t              action;
		logic [INDEX_W-1:0]   idx;
	} cbmt_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/cbmt_ifs.sv =====
`default_nettype none
interface cbmt_cmd_if
	import cbmt_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [INDEX_W-1:0]    counter_index;

	modport source (output valid, output action, output counter_index, input ready);
	modport sink   (input valid, input action, input counter_index, output ready);
endinterface

interface cbmt_res_if
	import cbmt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COUNT_WIDTH-1:0] counter_value;
	logic signed [COUNT_WIDTH-1:0] max_value;
	logic [HOLD_W-1:0]             max_holders;

	modport source (output valid, output counter_value, output max_value,
		output max_holders, input ready);
	modport sink   (input valid, input counter_value, input max_value,
		input max_holders, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbmt_cell.sv =====
`default_nettype none
module cbmt_cell
	import cbmt_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
	parameter int unsigned CNT_W       = 7,
	parameter int unsigned POS         = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire cbmt_ctl_t                     ctl_i,
	input  wire logic signed [COUNT_WIDTH-1:0] max_i,
	input  wire logic [CNT_W-1:0]              cnt_i,
	input  wire logic signed [COUNT_WIDTH-1:0] rep_i,
	output cbmt_ctl_t                          ctl_o,
	output logic signed [COUNT_WIDTH-1:0]      max_o,
	output logic [CNT_W-1:0]                   cnt_o,
	output logic signed [COUNT_WIDTH-1:0]      rep_o
);

	localparam logic signed [COUNT_WIDTH-1:0] VAL_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] VAL_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam bit IN_RANGE = (POS < (2 ** INDEX_W));

	logic signed [COUNT_WIDTH-1:0] val_q;
	logic signed [COUNT_WIDTH-1:0] nv;
	logic signed [COUNT_WIDTH-1:0] cur;
	logic                          hit;
	cbmt_ctl_t                     ctl_q;
	logic signed [COUNT_WIDTH-1:0] max_q;
	logic [CNT_W-1:0]              cnt_q;
	logic signed [COUNT_WIDTH-1:0] rep_q;

	assign hit = ctl_i.valid && IN_RANGE && (ctl_i.idx == INDEX_W'(POS));

	always_comb begin
		nv = val_q;
		unique case (ctl_i.action)
			ACT_INC: begin
				if (val_q != VAL_MAX)
					nv = val_q + COUNT_WIDTH'(1);
			end
			ACT_DEC: begin
				if (val_q != VAL_MIN)
					nv = val_q - COUNT_WIDTH'(1);
			end
			ACT_CLR:   nv = '0;
			ACT_QUERY: nv = val_q;
			default:   nv = val_q;
		endcase
	end

	assign cur = hit ? nv : val_q;

	// counter update, item pass-along, and running maximum and holder count of the cells passed so far
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			ctl_q <= '0;
			rep_q <= '0;
			max_q <= '0;
			cnt_q <= '0;
		end else if (adv) begin
			if (hit)
				val_q <= nv;
			ctl_q <= ctl_i;
			rep_q <= hit ? nv : rep_i;
			if (cur > max_i) begin
				max_q <= cur;
				cnt_q <= CNT_W'(1);
			end else if (cur == max_i) begin
				max_q <= max_i;
				cnt_q <= cnt_i + CNT_W'(1);
			end else begin
				max_q <= max_i;
				cnt_q <= cnt_i;
			end
		end
	end

	assign ctl_o = ctl_q;
	assign max_o = max_q;
	assign cnt_o = cnt_q;
	assign rep_o = rep_q;

endmodule
`default_nettype wire

// ===== rtl/counter_bank_max_tracker_top.sv =====
`default_nettype none
// Bank of NUM_COUNTERS saturating signed counters, all zero after reset. Each command item
// increments, decrements, clears or only queries one counter and returns one result item: that
// counter's new value, the largest value in the bank and how many counters hold it (low 7 bits).
// The counters sit in a row of cells; a command walks the row one cell per cycle while the row
// is not stalled, the addressed cell applies the action, and every cell folds its value into
// the maximum and holder count carried along, so each result reflects a full pass over the bank.
// Each cell registers the item, and the result is taken from the last cell; commands follow each
// other one per cycle, and the whole row stalls while a finished result is not taken.
module counter_bank_max_tracker_top
	import cbmt_pkg::*;
#(
	parameter int unsigned NUM_COUNTERS = NUM_COUNTERS_DEF,
	parameter int unsigned COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cbmt_cmd_if.sink    cmd,
	cbmt_res_if.source  res
);

	localparam int unsigned CNT_W = $clog2(NUM_COUNTERS + 1);
	localparam logic signed [COUNT_WIDTH-1:0] VAL_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	cbmt_ctl_t                     ctl [0:NUM_COUNTERS];
	logic signed [COUNT_WIDTH-1:0] mx  [0:NUM_COUNTERS];
	logic [CNT_W-1:0]              cnt [0:NUM_COUNTERS];
	logic signed [COUNT_WIDTH-1:0] rep [0:NUM_COUNTERS];
	logic                          adv;

	assign adv       = !ctl[NUM_COUNTERS].valid || res.ready;
	assign cmd.ready = adv;

	assign ctl[0].valid  = cmd.valid;
	assign ctl[0].action = action_t'(cmd.action);
	assign ctl[0].idx    = cmd.counter_index;
	assign mx[0]         = VAL_MIN;
	assign cnt[0]        = '0;
	assign rep[0]        = '0;

	for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_cell
		cbmt_cell #(
			.COUNT_WIDTH (COUNT_WIDTH),
			.CNT_W       (CNT_W),
			.POS         (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.ctl_i  (ctl[g]),
			.max_i  (mx[g]),
			.cnt_i  (cnt[g]),
			.rep_i  (rep[g]),
			.ctl_o  (ctl[g+1]),
			.max_o  (mx[g+1]),
			.cnt_o  (cnt[g+1]),
			.rep_o  (rep[g+1])
		);
	end

	assign res.valid         = ctl[NUM_COUNTERS].valid;
	assign res.counter_value = rep[NUM_COUNTERS];
	assign res.max_value     = mx[NUM_COUNTERS];
	assign res.max_holders   = HOLD_W'(cnt[NUM_COUNTERS]);

endmodule
`default_nettype wire
